// File: sv/tts_pkg.sv
`default_nettype none

package tts_pkg;

    // Table geometry and field widths
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int TIME_BITS = 32;
    localparam int PRIO_BITS = 8;
    localparam int CFG_BITS  = 16;

    // Reset value of the fallback sleep register
    localparam logic [CFG_BITS-1:0] FALLBACK_RESET = 16'd10;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_PICK     = 2'd1,
        CMD_COMPLETE = 2'd2
    } cmd_t;

    // Execution outcome of a completed task
    typedef enum logic [1:0] {
        OC_SUCCESS = 2'd0,
        OC_RETRY   = 2'd1,
        OC_FAILED  = 2'd2
    } outcome_t;

    // Task state reported with each result
    typedef enum logic [1:0] {
        TS_READY    = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_FINISHED = 2'd2,
        TS_ERROR    = 2'd3
    } task_state_t;

    // Result status carried on m_tuser
    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NOTHING_DUE = 3'd1,
        STAT_EMPTY       = 3'd2,
        STAT_INIT_FAILED = 3'd3,
        STAT_FULL        = 3'd4,
        STAT_NOT_RUNNING = 3'd5
    } stat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CPL,
        S_DONE
    } tts_state_t;

    // Configuration register byte offsets (bit 2 selects the register)
    localparam logic [2:0] ADDR_FALLBACK = 3'd0;

    // Input request payload, last declared field (now_ms) in the lowest bits
    typedef struct packed {
        logic [6:0]           pad;
        logic                 was_cancelled;
        logic [1:0]           outcome;
        logic [3:0]           done_slot;
        logic                 init_ok;
        logic                 is_periodic;
        logic [TIME_BITS-1:0] task_period_ms;
        logic [PRIO_BITS-1:0] task_priority;
        logic [TIME_BITS-1:0] first_run_ms;
        logic [TIME_BITS-1:0] now_ms;
    } in_item_t;

    // Result payload on m_tdata
    typedef struct packed {
        logic [1:0]           pad;
        logic [1:0]           new_state;
        logic [TIME_BITS-1:0] sleep_ms;
        logic [3:0]           slot;
    } out_item_t;

    // Full result held until the output register is free
    typedef struct packed {
        stat_t                status;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] sleep_ms;
        task_state_t          new_state;
    } result_t;

    // One slot entry in the task memory
    typedef struct packed {
        logic                 periodic;
        logic [TIME_BITS-1:0] period;
        logic [PRIO_BITS-1:0] prio;
        logic [TIME_BITS-1:0] next_run;
    } entry_t;

    // One entry presented to the scan unit
    typedef struct packed {
        logic                 sample;
        logic                 eligible;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] run;
        logic [PRIO_BITS-1:0] prio;
    } scan_in_t;

    // Running outcome of a pick scan
    typedef struct packed {
        logic                 have_ready;
        logic [TIME_BITS-1:0] earliest;
        logic                 have_best;
        logic [SLOT_BITS-1:0] best_slot;
    } scan_res_t;

endpackage

`default_nettype wire

// File: sv/tts_scan.sv
`default_nettype none

module tts_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tts_pkg::TIME_BITS-1:0] now_ms,
    input  wire tts_pkg::scan_in_t             scan_in,
    output tts_pkg::scan_res_t                 scan_res
);
    import tts_pkg::*;

    logic                 have_ready_reg, have_ready_next;
    logic [TIME_BITS-1:0] earliest_reg, earliest_next;
    logic                 have_best_reg, have_best_next;
    logic [SLOT_BITS-1:0] best_slot_reg, best_slot_next;
    logic [TIME_BITS-1:0] best_run_reg, best_run_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;
    logic                 take;

    // Due entry beats the current best on earlier time, then higher priority
    assign take = scan_in.run <= now_ms &&
                  (!have_best_reg || scan_in.run < best_run_reg ||
                   (scan_in.run == best_run_reg && scan_in.prio > best_prio_reg));

    // Fold one ready entry per cycle into the running result
    always_comb
    begin
        have_ready_next = have_ready_reg;
        earliest_next   = earliest_reg;
        have_best_next  = have_best_reg;
        best_slot_next  = best_slot_reg;
        best_run_next   = best_run_reg;
        best_prio_next  = best_prio_reg;
        if (start)
        begin
            have_ready_next = 1'b0;
            have_best_next  = 1'b0;
        end
        else if (scan_in.sample && scan_in.eligible)
        begin
            if (!have_ready_reg || scan_in.run < earliest_reg)
            begin
                earliest_next = scan_in.run;
            end
            have_ready_next = 1'b1;
            if (take)
            begin
                have_best_next = 1'b1;
                best_slot_next = scan_in.slot;
                best_run_next  = scan_in.run;
                best_prio_next = scan_in.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_ready_reg <= 1'b0;
            have_best_reg  <= 1'b0;
        end
        else
        begin
            have_ready_reg <= have_ready_next;
            have_best_reg  <= have_best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        earliest_reg  <= earliest_next;
        best_slot_reg <= best_slot_next;
        best_run_reg  <= best_run_next;
        best_prio_reg <= best_prio_next;
    end

    assign scan_res.have_ready = have_ready_reg;
    assign scan_res.earliest   = earliest_reg;
    assign scan_res.have_best  = have_best_reg;
    assign scan_res.best_slot  = best_slot_reg;

endmodule

`default_nettype wire

// File: sv/timed_task_table_scheduler.sv
`default_nettype none

// Earliest-deadline-first task table with NUM_SLOTS slots. Requests arrive on
// the s_ stream (kind on s_tuser: add, pick, complete); each add, pick or
// complete gives exactly one result on the m_ stream, kind 3 gives none.
// Slot contents (run time, priority, period, periodic flag) live in a
// single-port synchronous memory; valid and running marks are flip-flops
// cleared by reset, so no clearing pass is needed. One request is handled at
// a time: an add passes through the EXEC and DONE states, a complete through
// EXEC, CPL (for a running slot) and DONE, and a pick through EXEC, SCAN (for a
// non-empty table) and DONE, SCAN reading one entry per cycle. A
// finished result sits in the output register while the next request is
// accepted; a second result waits in the block until that register frees.
// The fallback sleep register lies at byte address 0 of the APB port.
module timed_task_table_scheduler (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_ms, first_run_ms, task_priority, task_period_ms, is_periodic,
    // init_ok, done_slot, outcome, was_cancelled
    input  wire logic [119:0] s_tdata,
    // command
    input  wire logic [1:0]   s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // slot, sleep_ms, new_state
    output logic [39:0]       m_tdata,
    // status
    output logic [2:0]        m_tuser,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tts_pkg::*;

    localparam logic [SLOT_BITS:0] SCAN_END = (SLOT_BITS + 1)'(NUM_SLOTS);

    tts_state_t            state_reg, state_next;
    cmd_t                  cmd_reg;
    in_item_t              in_reg;
    logic [NUM_SLOTS-1:0]  valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]  run_reg, run_next;
    logic [SLOT_BITS:0]    scan_cnt_reg, scan_cnt_next;
    logic                  rd_pend_reg;
    logic [SLOT_BITS-1:0]  rd_slot_reg;
    result_t               res_reg, res_next;
    logic                  m_valid_reg;
    result_t               m_res_reg;
    logic [CFG_BITS-1:0]   fallback_reg;

    // Slot memory ports
    entry_t                mem [NUM_SLOTS];
    entry_t                rd_data_reg;
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    entry_t                wr_data;

    logic                  scan_start;
    scan_in_t              scan_in;
    scan_res_t             scan_res;

    logic [SLOT_BITS:0]    free_enc;
    logic [SLOT_BITS-1:0]  cpl_slot;
    logic                  cpl_ok;
    logic                  scan_last;
    logic                  out_free;
    logic                  cfg_wr;

    // Lowest free slot; top bit marks that one was found
    function automatic logic [SLOT_BITS:0] find_free(input logic [NUM_SLOTS-1:0] v);
        logic [SLOT_BITS:0] r;
        r = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = {1'b1, SLOT_BITS'(i)};
            end
        end
        return r;
    endfunction

    assign free_enc  = find_free(valid_reg);
    assign cpl_slot  = in_reg.done_slot[SLOT_BITS-1:0];
    assign cpl_ok    = valid_reg[cpl_slot] && run_reg[cpl_slot];
    assign scan_last = (scan_cnt_reg == SCAN_END) && !rd_pend_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (cmd_t'(s_tuser))
                        CMD_ADD, CMD_PICK, CMD_COMPLETE: state_next = S_EXEC;
                        default:                         state_next = S_IDLE;
                    endcase
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_ADD:      state_next = S_DONE;
                    CMD_PICK:     state_next = (valid_reg == '0) ? S_DONE : S_SCAN;
                    CMD_COMPLETE: state_next = cpl_ok ? S_CPL : S_DONE;
                    default:      state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CPL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Table updates, memory accesses and result
    always_comb
    begin
        valid_next    = valid_reg;
        run_next      = run_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_start    = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = scan_cnt_reg[SLOT_BITS-1:0];
        wr_en         = 1'b0;
        wr_addr       = cpl_slot;
        wr_data       = rd_data_reg;
        res_next      = res_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!in_reg.init_ok)
                        begin
                            res_next = '{STAT_INIT_FAILED, '0, '0, TS_ERROR};
                        end
                        else if (!free_enc[SLOT_BITS])
                        begin
                            res_next = '{STAT_FULL, '0, '0, TS_READY};
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = free_enc[SLOT_BITS-1:0];
                            wr_data.periodic = in_reg.is_periodic;
                            wr_data.period   = in_reg.task_period_ms;
                            wr_data.prio     = in_reg.task_priority;
                            wr_data.next_run = in_reg.first_run_ms;
                            valid_next[free_enc[SLOT_BITS-1:0]] = 1'b1;
                            run_next[free_enc[SLOT_BITS-1:0]]   = 1'b0;
                            res_next = '{STAT_OK, free_enc[SLOT_BITS-1:0], '0, TS_READY};
                        end
                    end
                    CMD_PICK:
                    begin
                        if (valid_reg == '0)
                        begin
                            res_next = '{STAT_EMPTY, '0, '0, TS_READY};
                        end
                        else
                        begin
                            scan_start    = 1'b1;
                            scan_cnt_next = '0;
                        end
                    end
                    CMD_COMPLETE:
                    begin
                        if (!cpl_ok)
                        begin
                            res_next = '{STAT_NOT_RUNNING, cpl_slot, '0, TS_READY};
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = cpl_slot;
                        end
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end
            S_SCAN:
            begin
                // issue one slot read per cycle
                if (!scan_cnt_reg[SLOT_BITS])
                begin
                    rd_en         = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (scan_last)
                begin
                    if (scan_res.have_best)
                    begin
                        run_next[scan_res.best_slot] = 1'b1;
                        res_next = '{STAT_OK, scan_res.best_slot, '0, TS_RUNNING};
                    end
                    else if (scan_res.have_ready)
                    begin
                        res_next = '{STAT_NOTHING_DUE, '0,
                                     scan_res.earliest - in_reg.now_ms, TS_READY};
                    end
                    else
                    begin
                        res_next = '{STAT_NOTHING_DUE, '0,
                                     TIME_BITS'(fallback_reg), TS_READY};
                    end
                end
            end
            S_CPL:
            begin
                res_next.status   = STAT_OK;
                res_next.slot     = cpl_slot;
                res_next.sleep_ms = '0;
                if (in_reg.was_cancelled)
                begin
                    res_next.new_state = TS_FINISHED;
                end
                else
                begin
                    case (outcome_t'(in_reg.outcome))
                        OC_SUCCESS:
                        begin
                            if (rd_data_reg.periodic)
                            begin
                                // reschedule one period after now
                                wr_en              = 1'b1;
                                wr_data.next_run   = in_reg.now_ms + rd_data_reg.period;
                                res_next.new_state = TS_READY;
                            end
                            else
                            begin
                                res_next.new_state = TS_FINISHED;
                            end
                        end
                        OC_RETRY: res_next.new_state = TS_READY;
                        default:  res_next.new_state = TS_ERROR;
                    endcase
                end
                run_next[cpl_slot] = 1'b0;
                if (res_next.new_state != TS_READY)
                begin
                    valid_next[cpl_slot] = 1'b0;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Scan unit input: entry read in the previous cycle
    assign scan_in.sample   = rd_pend_reg;
    assign scan_in.eligible = valid_reg[rd_slot_reg] && !run_reg[rd_slot_reg];
    assign scan_in.slot     = rd_slot_reg;
    assign scan_in.run      = rd_data_reg.next_run;
    assign scan_in.prio     = rd_data_reg.prio;

    tts_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .now_ms   (in_reg.now_ms),
        .scan_in  (scan_in),
        .scan_res (scan_res)
    );

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            run_reg      <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            fallback_reg <= FALLBACK_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            run_reg      <= run_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_en && (state_reg == S_SCAN);
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr && paddr[2] == ADDR_FALLBACK[2])
            begin
                fallback_reg <= pwdata[CFG_BITS-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_addr;
        res_reg     <= res_next;
        if (s_tvalid && s_tready)
        begin
            in_reg  <= in_item_t'(s_tdata);
            cmd_reg <= cmd_t'(s_tuser);
        end
        if (state_reg == S_DONE && out_free)
        begin
            m_res_reg <= res_reg;
        end
    end

    // Result stream
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = out_item_t'{pad:       2'b00,
                                  new_state: m_res_reg.new_state,
                                  sleep_ms:  m_res_reg.sleep_ms,
                                  slot:      4'(m_res_reg.slot)};

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ADDR_FALLBACK[2]) ? 32'(fallback_reg) : 32'd0;

endmodule

`default_nettype wire

// File: sv/tts_checker.sv
`default_nettype none

module tts_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [39:0]  m_tdata,
    input wire logic [2:0]   m_tuser
);
    import tts_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One request at a time: a served request is followed by a busy cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == CMD_ADD || s_tuser == CMD_PICK || s_tuser == CMD_COMPLETE)
        |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Empty-table result carries no slot, sleep or state
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[37:0] == '0)
        else $error("empty-table result has stray fields");

    // Rejected add reports the error state
    a_init_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_INIT_FAILED |-> m_tdata[37:36] == TS_ERROR)
        else $error("rejected add without error state");

endmodule

bind timed_task_table_scheduler tts_checker u_tts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/tb_timed_task_table_scheduler.sv
`timescale 1ns / 1ps

module tb_timed_task_table_scheduler;
    import tts_pkg::*;

    localparam int         CLK_PERIOD    = 12;
    localparam int         RESET_CYCLES  = 9;
    localparam int         SETTLE_CYCLES = 40;   // longest request is a pick
    localparam int         HOLD_CYCLES   = 400;
    localparam logic [1:0] CMD_UNKNOWN   = 2'd3; // kind the block drops silently
    localparam logic [1:0] OC_UNDEFINED  = 2'd3; // outcome handled as failed

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // now_ms, first_run_ms, task_priority, task_period_ms, is_periodic,
    // init_ok, done_slot, outcome, was_cancelled
    logic [119:0] s_tdata = '0;
    // command
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // slot, sleep_ms, new_state
    logic [39:0]  m_tdata;
    // status
    logic [2:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    timed_task_table_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the task table and the fallback register
    logic                 tbl_valid    [NUM_SLOTS];
    task_state_t          tbl_state    [NUM_SLOTS];
    logic [TIME_BITS-1:0] tbl_run      [NUM_SLOTS];
    logic [PRIO_BITS-1:0] tbl_prio     [NUM_SLOTS];
    logic [TIME_BITS-1:0] tbl_period   [NUM_SLOTS];
    logic                 tbl_periodic [NUM_SLOTS];
    logic [CFG_BITS-1:0]  fallback_ms = FALLBACK_RESET;

    result_t              expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    logic [TIME_BITS-1:0] ms_cursor = '0;

    int failures = 0;
    int n_add = 0, n_pick = 0, n_complete = 0, n_ignored = 0, n_checked = 0;
    int n_full = 0, n_fallback = 0, n_due_sleep = 0, n_not_running = 0, n_periodic = 0;

    // Clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(6_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Scheduler behavior: apply one request to the shadow table, return its result
    function automatic result_t schedule_request(input logic [1:0] kind, input in_item_t d);
        result_t              r;
        logic                 any, have_best, have_ready;
        int                   best;
        logic [TIME_BITS-1:0] earliest;
        logic [3:0]           s;
        task_state_t          st;
        int                   i;

        r = '0;
        any = 1'b0;
        have_best = 1'b0;
        have_ready = 1'b0;
        best = 0;
        earliest = '0;
        case (kind)
            CMD_ADD:
            begin
                if (!d.init_ok)
                begin
                    r.status = STAT_INIT_FAILED;
                    r.new_state = TS_ERROR;
                end
                else
                begin
                    r.status = STAT_FULL;
                    r.new_state = TS_READY;
                    for (i = 0; i < NUM_SLOTS && r.status == STAT_FULL; i++)
                    begin
                        if (!tbl_valid[i])
                        begin
                            tbl_valid[i]    = 1'b1;
                            tbl_state[i]    = TS_READY;
                            tbl_run[i]      = d.first_run_ms;
                            tbl_prio[i]     = d.task_priority;
                            tbl_period[i]   = d.task_period_ms;
                            tbl_periodic[i] = d.is_periodic;
                            r.status = STAT_OK;
                            r.slot = SLOT_BITS'(i);
                        end
                    end
                    if (r.status == STAT_FULL)
                        n_full++;
                end
            end
            CMD_PICK:
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        any = 1'b1;
                        if (tbl_state[i] == TS_READY)
                        begin
                            if (!have_ready || tbl_run[i] < earliest)
                                earliest = tbl_run[i];
                            have_ready = 1'b1;
                            if (tbl_run[i] <= d.now_ms &&
                                (!have_best || tbl_run[i] < tbl_run[best] ||
                                 (tbl_run[i] == tbl_run[best] && tbl_prio[i] > tbl_prio[best])))
                            begin
                                best = i;
                                have_best = 1'b1;
                            end
                        end
                    end
                end
                if (!any)
                    r.status = STAT_EMPTY;
                else if (have_best)
                begin
                    tbl_state[best] = TS_RUNNING;
                    r.status = STAT_OK;
                    r.slot = SLOT_BITS'(best);
                    r.new_state = TS_RUNNING;
                end
                else
                begin
                    r.status = STAT_NOTHING_DUE;
                    if (have_ready && earliest > d.now_ms)
                    begin
                        r.sleep_ms = earliest - d.now_ms;
                        n_due_sleep++;
                    end
                    else
                    begin
                        r.sleep_ms = {{(TIME_BITS - CFG_BITS){1'b0}}, fallback_ms};
                        n_fallback++;
                    end
                end
            end
            default:
            begin
                // completion
                s = d.done_slot;
                r.slot = s;
                if (!tbl_valid[s] || tbl_state[s] != TS_RUNNING)
                begin
                    r.status = STAT_NOT_RUNNING;
                    n_not_running++;
                end
                else
                begin
                    if (d.was_cancelled)
                        st = TS_FINISHED;
                    else if (d.outcome == OC_SUCCESS)
                    begin
                        if (tbl_periodic[s])
                        begin
                            tbl_run[s] = d.now_ms + tbl_period[s];
                            st = TS_READY;
                            n_periodic++;
                        end
                        else
                            st = TS_FINISHED;
                    end
                    else if (d.outcome == OC_RETRY)
                        st = TS_READY;
                    else
                        st = TS_ERROR;
                    tbl_state[s] = st;
                    if (st == TS_FINISHED || st == TS_ERROR)
                        tbl_valid[s] = 1'b0;
                    r.status = STAT_OK;
                    r.new_state = st;
                end
            end
        endcase
        return r;
    endfunction

    // Request payload with every field but the pad random
    function automatic in_item_t random_item();
        in_item_t d;
        d.pad            = '0;
        d.now_ms         = $urandom();
        d.first_run_ms   = $urandom();
        d.task_priority  = 8'($urandom_range(255));
        d.task_period_ms = $urandom();
        d.is_periodic    = 1'($urandom_range(1));
        d.init_ok        = 1'($urandom_range(1));
        d.done_slot      = 4'($urandom_range(NUM_SLOTS - 1));
        d.outcome        = 2'($urandom_range(3));
        d.was_cancelled  = 1'($urandom_range(1));
        return d;
    endfunction

    function automatic in_item_t add_item(input logic [31:0] run, input logic [7:0] prio,
                                          input logic [31:0] period, input logic periodic,
                                          input logic ok);
        in_item_t d;
        d = random_item();
        d.first_run_ms   = run;
        d.task_priority  = prio;
        d.task_period_ms = period;
        d.is_periodic    = periodic;
        d.init_ok        = ok;
        return d;
    endfunction

    function automatic in_item_t pick_item(input logic [31:0] now);
        in_item_t d;
        d = random_item();
        d.now_ms = now;
        return d;
    endfunction

    function automatic in_item_t done_item(input logic [31:0] now, input logic [3:0] slot,
                                           input logic [1:0] oc, input logic cancelled);
        in_item_t d;
        d = random_item();
        d.now_ms        = now;
        d.done_slot     = slot;
        d.outcome       = oc;
        d.was_cancelled = cancelled;
        return d;
    endfunction

    // Offer one request and wait for it to be taken; valid stays up on return
    task automatic send_request(input logic [1:0] kind, input in_item_t d);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        case (kind)
            CMD_ADD:      n_add++;
            CMD_PICK:     n_pick++;
            CMD_COMPLETE: n_complete++;
            default:      n_ignored++;
        endcase
        if (kind != CMD_UNKNOWN)
            expected_results.insert(expected_results.size(), schedule_request(kind, d));
    endtask

    // Lower valid, wait out every outstanding result and any trailing work
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fallback(input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FALLBACK;
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fallback_ms = value;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Random request shaped around the current table: due times near the
    // cursor, small priorities for ties, completions aimed at running slots
    task automatic make_random_request(input int add_pct, output logic [1:0] kind,
                                       output in_item_t d);
        int running [NUM_SLOTS];
        int n_running;
        int roll;
        int i;

        n_running = 0;
        d = random_item();
        if ($urandom_range(19) == 0)
            ms_cursor = $urandom();
        else
            ms_cursor = ms_cursor + $urandom_range(0, 30);
        if ($urandom_range(19) != 0)
            d.now_ms = ms_cursor;
        roll = $urandom_range(99);
        if (roll < 2)
            kind = CMD_UNKNOWN;
        else if (roll < add_pct)
        begin
            kind = CMD_ADD;
            d.init_ok = ($urandom_range(9) != 0);
            if ($urandom_range(19) != 0)
                d.first_run_ms = ms_cursor + 10 * $urandom_range(0, 6);
            if ($urandom_range(1) == 0)
                d.task_priority = 8'($urandom_range(3));
            if ($urandom_range(9) != 0)
                d.task_period_ms = $urandom_range(1, 200);
        end
        else if (roll < add_pct + (100 - add_pct) / 2)
            kind = CMD_PICK;
        else
        begin
            kind = CMD_COMPLETE;
            for (i = 0; i < NUM_SLOTS; i++)
                if (tbl_valid[i] && tbl_state[i] == TS_RUNNING)
                begin
                    running[n_running] = i;
                    n_running++;
                end
            if (n_running != 0 && $urandom_range(99) < 85)
                d.done_slot = 4'(running[$urandom_range(n_running - 1)]);
            d.was_cancelled = ($urandom_range(99) < 15);
            if ($urandom_range(1) == 0)
                d.outcome = OC_SUCCESS;
        end
    endtask

    // Edge cases: empty table, bad completions, wrap, ties, all running
    task automatic test_directed();
        send_request(CMD_PICK, pick_item($urandom()));
        send_request(CMD_COMPLETE, done_item(0, 4'(NUM_SLOTS - 1), OC_SUCCESS, 1'b0));
        send_request(CMD_ADD, add_item($urandom(), 8'($urandom()), $urandom(), 1'b1, 1'b0));
        send_request(CMD_ADD, add_item(32'h0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_request(CMD_ADD, add_item(32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, 1'b1));
        send_request(CMD_PICK, pick_item(32'h0));
        send_request(CMD_PICK, pick_item(32'h0));
        send_request(CMD_COMPLETE, done_item(0, 1, OC_SUCCESS, 1'b0));
        // periodic reschedule wraps past the top of the time range
        send_request(CMD_COMPLETE, done_item(5, 0, OC_SUCCESS, 1'b0));
        send_request(CMD_PICK, pick_item(32'd3));
        send_request(CMD_PICK, pick_item(32'hFFFF_FFFF));
        send_request(CMD_PICK, pick_item(32'hFFFF_FFFF));
        // every task running: sleep falls back to the register
        send_request(CMD_PICK, pick_item(32'h0));
        send_request(CMD_COMPLETE, done_item($urandom(), 0, OC_RETRY, 1'b0));
        send_request(CMD_COMPLETE, done_item($urandom(), 1, OC_UNDEFINED, 1'b0));
        send_request(CMD_PICK, pick_item(32'd100));
        send_request(CMD_COMPLETE, done_item($urandom(), 0, OC_SUCCESS, 1'b1));
        send_request(CMD_UNKNOWN, random_item());
        // equal run times: higher priority first, then lower slot
        send_request(CMD_ADD, add_item(32'd50, 8'd7, 32'd20, 1'b0, 1'b1));
        send_request(CMD_ADD, add_item(32'd50, 8'd9, 32'd20, 1'b0, 1'b1));
        send_request(CMD_ADD, add_item(32'd50, 8'd9, 32'd20, 1'b1, 1'b1));
        send_request(CMD_PICK, pick_item(32'd50));
        send_request(CMD_PICK, pick_item(32'd50));
        send_request(CMD_PICK, pick_item(32'd50));
        send_request(CMD_COMPLETE, done_item(32'd60, 1, OC_FAILED, 1'b0));
        send_request(CMD_COMPLETE, done_item(32'd60, 2, OC_SUCCESS, 1'b0));
        drain_results();
    endtask

    task automatic test_random_traffic(input int count, input int add_pct);
        logic [1:0] kind;
        in_item_t   d;
        int         sent;

        sent = 0;
        while (sent < count)
        begin
            make_random_request(add_pct, kind, d);
            send_request(kind, d);
            if (kind != CMD_UNKNOWN)
                sent++;
        end
        drain_results();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        logic [1:0] kind;
        in_item_t   d;

        set_idling(0, 0);
        hold_requests++;
        repeat (40)
        begin
            make_random_request(50, kind, d);
            send_request(kind, d);
        end
        drain_results();
    endtask

    // Receiver ready, with random stalls and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t   want;
        out_item_t got;

        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d slot %0d",
                       m_tuser, got.slot);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    failures++;
                end
                if (got.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, got.slot);
                    failures++;
                end
                if (got.sleep_ms !== want.sleep_ms)
                begin
                    $error("sleep_ms: expected %0d, got %0d", want.sleep_ms, got.sleep_ms);
                    failures++;
                end
                if (got.new_state !== want.new_state)
                begin
                    $error("new_state: expected %0d, got %0d", want.new_state, got.new_state);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(16, 65);
        test_directed();
        write_fallback(16'h0000);
        test_random_traffic(170, 40);

        set_idling(65, 16);
        write_fallback(16'hFFFF);
        ms_cursor = 32'hFFFF_FF00;
        test_random_traffic(170, 55);

        set_idling(0, 0);
        write_fallback(16'($urandom()));
        test_random_traffic(160, 35);
        test_backpressure();

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        $display("Covered %0d adds, %0d picks, %0d completions, %0d ignored kinds;",
                 n_add, n_pick, n_complete, n_ignored);
        $display("%0d results checked; table full %0d, fallback sleeps %0d,",
                 n_checked, n_full, n_fallback);
        $display("timed sleeps %0d, bad completions %0d, reschedules %0d.",
                 n_due_sleep, n_not_running, n_periodic);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: timed_task_table_scheduler.f
sv/tts_pkg.sv
sv/tts_scan.sv
sv/timed_task_table_scheduler.sv
sv/tts_checker.sv
bench/tb_timed_task_table_scheduler.sv
